// File: design/pid_speed_controller_assert.svh
// Assertion macros for the PID speed controller.
// Included by the top level; no other dependencies.
`ifndef PID_SPEED_CONTROLLER_ASSERT_SVH
`define PID_SPEED_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define PSC_ASSERT_IMP(label, ck, rstn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define PSC_ASSERT_NXT(label, ck, rstn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define PSC_ASSERT_IMP(label, ck, rstn, ante, cons)
`define PSC_ASSERT_NXT(label, ck, rstn, ante, cons)
`endif

`endif

// File: design/psc_pkg.sv
// Shared types and constants for the PID speed controller.
// No dependencies.
`timescale 1ns / 1ps

package psc_pkg;

    typedef enum logic [2:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_REVERSE  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [7:0]  setpoint;
        logic signed [10:0] gain_p;
        logic signed [10:0] gain_i;
        logic signed [10:0] gain_d;
        logic               reverse;
    } cfg_t;

    typedef struct packed {
        logic err_stage;
        logic prod_stage;
        logic sum_stage;
        logic out_stage;
    } pipe_load_t;

    localparam int CFG_DATA_W      = 11;
    localparam int CFG_INDEX_W     = 3;
    localparam int GAIN_W          = 11;
    localparam int ERR_W           = 9;
    localparam int DELTA_W         = 10;
    localparam int SCALE_SHIFT     = 6;
    localparam int RECIP_FIVE      = 205;
    localparam int RECIP_SHIFT     = 10;
    localparam int TOTAL_POS_LIMIT = 40960;
    localparam int TOTAL_NEG_LIMIT = -41280;
    localparam logic [7:0] DRIVE_MAX = 8'h7f;
    localparam logic [7:0] DRIVE_MIN = 8'h80;

endpackage

// File: design/psc_cfg_regs.sv
// Configuration register file for the PID speed controller.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_cfg_regs
    import psc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SETPOINT: cfg_next.setpoint = cfg_data[7:0];
                REG_GAIN_P:   cfg_next.gain_p   = cfg_data;
                REG_GAIN_I:   cfg_next.gain_i   = cfg_data;
                REG_GAIN_D:   cfg_next.gain_d   = cfg_data;
                REG_REVERSE:  cfg_next.reverse  = cfg_data[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// File: design/psc_error_stage.sv
// Error, derivative and saturating integrator stage; holds the loop state.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_error_stage
    import psc_pkg::*;
#(
    parameter int INTEGRATOR_WIDTH = 24
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [7:0]                         velocity_raw,
    input  cfg_t                               cfg,
    output logic signed [ERR_W-1:0]            err,
    output logic signed [DELTA_W-1:0]          delta,
    output logic signed [INTEGRATOR_WIDTH-1:0] sum
);

    localparam int W = INTEGRATOR_WIDTH;

    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [ERR_W-1:0]   last_error_next;
    logic signed [W-1:0]       error_sum_reg;
    logic signed [W-1:0]       error_sum_next;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [W-1:0]       sum_reg;

    logic signed [8:0]         vel_ext;
    logic signed [8:0]         vel_adj;
    logic signed [9:0]         err_wide;
    logic signed [DELTA_W-1:0] delta_next;
    logic signed [W:0]         sum_wide;

    always_comb
    begin
        vel_ext         = {velocity_raw[7], velocity_raw};
        vel_adj         = cfg.reverse ? 9'(-vel_ext) : vel_ext;
        err_wide        = {{2{cfg.setpoint[7]}}, cfg.setpoint} - {vel_adj[8], vel_adj};
        last_error_next = err_wide[ERR_W-1:0];
        delta_next      = {last_error_next[ERR_W-1], last_error_next}
                          - {last_error_reg[ERR_W-1], last_error_reg};
        sum_wide        = {error_sum_reg[W-1], error_sum_reg}
                          + {{(W-8){last_error_next[ERR_W-1]}}, last_error_next};
        // saturate on overflow
        if (sum_wide[W] != sum_wide[W-1])
            error_sum_next = sum_wide[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            error_sum_next = sum_wide[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else if (load)
        begin
            last_error_reg <= last_error_next;
            error_sum_reg  <= error_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg   <= last_error_next;
            delta_reg <= delta_next;
            sum_reg   <= error_sum_next;
        end
    end

    assign err   = err_reg;
    assign delta = delta_reg;
    assign sum   = sum_reg;

endmodule

// File: design/psc_product_stage.sv
// Gain products and their registered sum.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_product_stage
    import psc_pkg::*;
#(
    parameter int INTEGRATOR_WIDTH = 24
)
(
    input  logic                                  clk,
    input  pipe_load_t                            load,
    input  cfg_t                                  cfg,
    input  logic signed [ERR_W-1:0]               err,
    input  logic signed [DELTA_W-1:0]             delta,
    input  logic signed [INTEGRATOR_WIDTH-1:0]    sum,
    output logic signed [INTEGRATOR_WIDTH+12:0]   total
);

    localparam int W  = INTEGRATOR_WIDTH;
    localparam int TW = W + 13;
    localparam int PW = GAIN_W + ERR_W;
    localparam int IW = GAIN_W + W;
    localparam int DW = GAIN_W + DELTA_W;

    logic signed [PW-1:0] prod_p_reg;
    logic signed [IW-1:0] prod_i_reg;
    logic signed [DW-1:0] prod_d_reg;
    logic signed [TW-1:0] total_reg;

    logic signed [PW-1:0] prod_p_next;
    logic signed [IW-1:0] prod_i_next;
    logic signed [DW-1:0] prod_d_next;
    logic signed [TW-1:0] total_next;

    always_comb
    begin
        prod_p_next = PW'($signed(cfg.gain_p)) * PW'(err);
        prod_i_next = IW'($signed(cfg.gain_i)) * IW'(sum);
        prod_d_next = DW'($signed(cfg.gain_d)) * DW'(delta);
        total_next  = TW'(prod_p_reg) + TW'(prod_i_reg) + TW'(prod_d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load.prod_stage)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (load.sum_stage)
            total_reg <= total_next;
    end

    assign total = total_reg;

endmodule

// File: design/psc_scale_stage.sv
// Divide by 320 toward zero, clamp to the drive range, result register.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_scale_stage
    import psc_pkg::*;
#(
    parameter int INTEGRATOR_WIDTH = 24
)
(
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [INTEGRATOR_WIDTH+12:0] total,
    output logic [7:0]                          drive,
    output logic                                clamped
);

    localparam int TW = INTEGRATOR_WIDTH + 13;
    localparam logic signed [TW-1:0] POS_LIM = TW'(TOTAL_POS_LIMIT);
    localparam logic signed [TW-1:0] NEG_LIM = TW'(TOTAL_NEG_LIMIT);

    logic [7:0]  drive_reg;
    logic [7:0]  drive_next;
    logic        clamped_reg;
    logic        clamped_next;

    logic        neg;
    logic [15:0] mag;
    logic [9:0]  coarse;
    logic [17:0] recip_prod;
    logic [7:0]  quot;

    always_comb
    begin
        neg        = total[TW-1];
        mag        = neg ? 16'(-total[15:0]) : total[15:0];
        coarse     = mag[15:SCALE_SHIFT];
        recip_prod = 18'(coarse) * 18'(RECIP_FIVE);
        quot       = recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        if (total >= POS_LIM)
        begin
            drive_next   = DRIVE_MAX;
            clamped_next = 1'b1;
        end
        else if (total <= NEG_LIM)
        begin
            drive_next   = DRIVE_MIN;
            clamped_next = 1'b1;
        end
        else
        begin
            drive_next   = neg ? 8'(-quot) : quot;
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

    assign drive   = drive_reg;
    assign clamped = clamped_reg;

endmodule

// File: design/pid_speed_controller.sv
// Discrete PID speed controller: four-stage pipeline and flow control.
// Depends on psc_pkg, psc_cfg_regs, psc_error_stage, psc_product_stage,
// psc_scale_stage and pid_speed_controller_assert.svh.
//
// Usage:
//   s_axis carries one velocity sample per transaction (tdata[7:0]).
//   m_axis returns one drive value per sample (tdata[7:0], signed) with
//   tuser set when the value was clamped to -128..127.
//   cfg_wr_en/cfg_index/cfg_data write setpoint, gains and reverse; write
//   only while no sample is in flight.
//   m_axis_tvalid rises once a sample reaches the last of four register
//   stages, the first loaded at the accepting edge. Without output
//   stalls, throughput is one sample per cycle; the loop state is updated
//   in the cycle a sample is taken, so consecutive samples need no spacing.
//   The drive is held in an output register; while the receiver stalls,
//   empty stages ahead of it still fill, and s_axis_tready drops only when
//   all four stages are occupied.
//   Reset clears the configuration, integrator, last error and all stage
//   valid flags; the pipeline is empty and ready straight after reset.
`timescale 1ns / 1ps

`include "pid_speed_controller_assert.svh"

module pid_speed_controller
    import psc_pkg::*;
#(
    parameter int INTEGRATOR_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] velocity_raw
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] drive
    output logic                   m_axis_tuser,   // [0] clamped
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int W = INTEGRATOR_WIDTH;

    cfg_t       cfg;
    pipe_load_t load;

    logic err_valid_reg;
    logic prod_valid_reg;
    logic sum_valid_reg;
    logic out_valid_reg;

    logic out_ready;
    logic sum_ready;
    logic prod_ready;
    logic err_ready;

    logic signed [ERR_W-1:0]   err;
    logic signed [DELTA_W-1:0] delta;
    logic signed [W-1:0]       sum;
    logic signed [W+12:0]      total;

    // each stage may advance when the one ahead is empty or advancing
    always_comb
    begin
        out_ready  = !out_valid_reg || m_axis_tready;
        sum_ready  = !sum_valid_reg || out_ready;
        prod_ready = !prod_valid_reg || sum_ready;
        err_ready  = !err_valid_reg || prod_ready;

        load.err_stage  = s_axis_tvalid && err_ready;
        load.prod_stage = err_valid_reg && prod_ready;
        load.sum_stage  = prod_valid_reg && sum_ready;
        load.out_stage  = sum_valid_reg && out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (err_ready)
                err_valid_reg <= s_axis_tvalid;
            if (prod_ready)
                prod_valid_reg <= err_valid_reg;
            if (sum_ready)
                sum_valid_reg <= prod_valid_reg;
            if (out_ready)
                out_valid_reg <= sum_valid_reg;
        end
    end

    psc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psc_error_stage #(.INTEGRATOR_WIDTH(W)) u_error_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load.err_stage),
        .velocity_raw (s_axis_tdata),
        .cfg          (cfg),
        .err          (err),
        .delta        (delta),
        .sum          (sum)
    );

    psc_product_stage #(.INTEGRATOR_WIDTH(W)) u_product_stage
    (
        .clk   (clk),
        .load  (load),
        .cfg   (cfg),
        .err   (err),
        .delta (delta),
        .sum   (sum),
        .total (total)
    );

    psc_scale_stage #(.INTEGRATOR_WIDTH(W)) u_scale_stage
    (
        .clk     (clk),
        .load    (load.out_stage),
        .total   (total),
        .drive   (m_axis_tdata),
        .clamped (m_axis_tuser)
    );

    assign s_axis_tready = err_ready;
    assign m_axis_tvalid = out_valid_reg;

    `PSC_ASSERT_IMP(a_clamp_at_limit, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == DRIVE_MAX || m_axis_tdata == DRIVE_MIN)
    `PSC_ASSERT_NXT(a_accept_fills_stage, clk, rst_n, s_axis_tvalid && s_axis_tready, err_valid_reg)
    `PSC_ASSERT_IMP(a_full_pipe_blocks, clk, rst_n, out_valid_reg && !m_axis_tready && sum_valid_reg && prod_valid_reg && err_valid_reg, !s_axis_tready)

endmodule

// File: tb/sv/tb_pid_speed_controller.sv
// Self-checking bench for pid_speed_controller: drives velocity samples and register
// writes, mirrors the PID loop arithmetic in a shadow class and checks every drive value.
// Depends on psc_pkg and the pid_speed_controller RTL.
`timescale 1ns / 1ps

module tb_pid_speed_controller;
    import psc_pkg::*;

    localparam int SUM_W = 24;
    localparam int PIPE_DEPTH = 4;
    localparam int HOLD_CYCLES = 200;
    localparam int LIMIT = 400000;
    localparam longint PID_SCALE = 320;
    localparam longint DRIVE_CEIL = 127;
    localparam longint DRIVE_FLOOR = -128;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST = 3'd7;

    typedef struct packed {
        logic [7:0] drive;
        logic       clamped;
    } drive_result_t;

    class pid_loop_shadow;
        cfg_t                    cfg;
        logic signed [8:0]       last_err;
        logic signed [SUM_W-1:0] err_sum;
        drive_result_t           pending_drives[$];
        int unsigned             mismatches;
        int unsigned             drives_seen;

        function new();
            cfg = '0;
            last_err = '0;
            err_sum = '0;
            mismatches = 0;
            drives_seen = 0;
        endfunction

        function int pending();
            return pending_drives.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SETPOINT: cfg.setpoint = data[7:0];
                REG_GAIN_P:   cfg.gain_p = data;
                REG_GAIN_I:   cfg.gain_i = data;
                REG_GAIN_D:   cfg.gain_d = data;
                REG_REVERSE:  cfg.reverse = data[0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic [7:0] raw);
            longint speed, err, delta, sum_next, sum_max, total, quo;
            drive_result_t res;
            sum_max = (longint'(1) << (SUM_W - 1)) - 1;
            speed = longint'(signed'(raw));
            if (cfg.reverse)
                speed = -speed;
            err = longint'(signed'(cfg.setpoint)) - speed;
            delta = err - longint'(last_err);
            last_err = err[8:0];
            sum_next = longint'(err_sum) + err;
            if (sum_next > sum_max)
                sum_next = sum_max;
            if (sum_next < -sum_max - 1)
                sum_next = -sum_max - 1;
            err_sum = sum_next[SUM_W-1:0];
            total = longint'(signed'(cfg.gain_p)) * err
                  + longint'(signed'(cfg.gain_i)) * sum_next
                  + longint'(signed'(cfg.gain_d)) * delta;
            quo = total / PID_SCALE;
            res.clamped = 1'b0;
            if (quo > DRIVE_CEIL) begin
                quo = DRIVE_CEIL;
                res.clamped = 1'b1;
            end
            if (quo < DRIVE_FLOOR) begin
                quo = DRIVE_FLOOR;
                res.clamped = 1'b1;
            end
            res.drive = quo[7:0];
            pending_drives.push_back(res);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            mismatches++;
            $display("drive %0d: %s got %0h want %0h", drives_seen, what, got, want);
        endtask

        task compare_drive(logic [7:0] drive, logic clamped);
            drive_result_t want;
            drives_seen++;
            if (pending_drives.size() == 0) begin
                report("unexpected transaction", drive, 8'h00);
                return;
            end
            want = pending_drives.pop_front();
            if (drive !== want.drive)
                report("drive", drive, want.drive);
            if (clamped !== want.clamped)
                report("clamped", {7'b0, clamped}, {7'b0, want.clamped});
        endtask
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  cycle_count = 0;
    bit  hold_req = 1'b0;
    logic rx_hold = 1'b0;

    pid_loop_shadow loop_shadow = new();

    pid_speed_controller #(.INTEGRATOR_WIDTH(SUM_W)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("pid_speed_controller: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

    // hold the receiver off so the pipeline fills and stalls its input
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            loop_shadow.compare_drive(m_axis_tdata, m_axis_tuser);

    task automatic send_sample(input logic [7:0] raw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= raw;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        loop_shadow.take_sample(raw);
        @(negedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (loop_shadow.pending() != 0);
        repeat (PIPE_DEPTH) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        loop_shadow.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic signed [7:0] sp, input logic [10:0] gp,
                                  input logic [10:0] gi, input logic [10:0] gd,
                                  input logic rev);
        write_reg(REG_SETPOINT, {{3{sp[7]}}, sp});
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_REVERSE, {10'($urandom), rev});
        // drop a write on an unused index; the loop must ignore it
        write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                  CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [10:0] pick_gain();
        case ($urandom_range(3))
            0: return 11'($urandom);
            1: return $urandom_range(1) ? 11'h400 : 11'h3ff;
            2: return 11'($urandom_range(16)) - 11'd8;
            default: return 11'd0;
        endcase
    endfunction

    // mostly samples close to the setpoint so the loop stays in its working range
    function automatic logic [7:0] pick_sample();
        logic [7:0] speed;
        if ($urandom_range(99) < 70)
        begin
            speed = loop_shadow.cfg.setpoint + 8'($urandom_range(16)) - 8'd8;
            return loop_shadow.cfg.reverse ? -speed : speed;
        end
        return 8'($urandom);
    endfunction

    task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                             input bit with_hold);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(negedge clk);
        for (int n = 0; n < count; n++)
        begin
            if (n % 90 == 0)
            begin
                settle();
                apply_settings(8'($urandom), pick_gain(), pick_gain(), pick_gain(),
                               1'($urandom_range(1)));
            end
            if (with_hold && n == count / 2)
                hold_req = 1'b1;
            send_sample(pick_sample());
        end
        settle();
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_sample(8'h00);
        send_sample(8'h7f);
        send_sample(8'h80);
        send_sample(8'hff);
        settle();

        // quotients that truncate toward zero on both signs
        apply_settings(8'sd0, 11'h400, 11'd0, 11'd0, 1'b0);
        send_sample(8'hff);
        send_sample(8'h01);
        send_sample(8'h20);
        send_sample(8'h40);
        settle();

        apply_settings(8'sd127, 11'h3ff, 11'h400, 11'd640, 1'b0);
        send_sample(8'h80);
        send_sample(8'h80);
        send_sample(8'h80);
        send_sample(8'h7f);
        settle();

        // reversed most negative sample gives the largest negative error
        apply_settings(-8'sd128, -11'sd640, 11'd1, 11'h400, 1'b1);
        send_sample(8'h80);
        send_sample(8'h7f);
        send_sample(8'h00);
        settle();

        apply_settings(8'sd5, 11'd7, 11'd3, 11'd2, 1'b1);
        send_sample(8'hfb);
        send_sample(8'h05);
        send_sample(8'haa);
        send_sample(8'h55);
        settle();

        run_phase(8, 69, 340, 1'b0);
        run_phase(69, 8, 340, 1'b1);
        run_phase(0, 0, 340, 1'b0);

        // push the integrator hard in both directions
        apply_settings(8'sd127, pick_gain(), 11'd1, pick_gain(), 1'b0);
        for (int n = 0; n < 40; n++)
            send_sample(8'h80);
        settle();
        apply_settings(-8'sd128, pick_gain(), 11'd1, pick_gain(), 1'b0);
        for (int n = 0; n < 40; n++)
            send_sample(8'h7f);
        settle();

        repeat (2 * PIPE_DEPTH) @(negedge clk);
        if (loop_shadow.mismatches == 0 && loop_shadow.pending() == 0)
            $display("pid_speed_controller: match");
        else
            $display("pid_speed_controller: mismatch");
        $finish;
    end

endmodule
